// File: sv/page_run_allocator_macros.svh
// ----------------------------------------------------------------------------
// page_run_allocator_macros
// assertion macros shared by the page run allocator checker
// ----------------------------------------------------------------------------
`ifndef PAGE_RUN_ALLOCATOR_MACROS_SVH
`define PAGE_RUN_ALLOCATOR_MACROS_SVH

// implication checked at every clock edge outside reset
`define PRA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication whose consequence is checked in the cycle after the antecedent
`define PRA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/pra_pkg.sv
// ----------------------------------------------------------------------------
// pra_pkg
// types and constants of the page run allocator
// ----------------------------------------------------------------------------
package pra_pkg;

   localparam int BYTES_W    = 23;
   localparam int FPAGE_W    = 10;
   localparam int START_W    = 10;
   localparam int COUNT_W    = 11;
   localparam int WANT_W     = 12;
   localparam int PAGE_SHIFT = 12;
   localparam int PAGE_MASK  = 4095;

   // register indexes of the configuration port
   localparam int REG_PLACEMENT_MODE = 0;

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      MODE_NEXT_FIT = 1'b0,
      MODE_BEST_FIT = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_RUN    = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_BAD       = 2'd3
   } status_type;

   typedef struct packed {
      op_type               operation;
      logic [BYTES_W-1:0]   request_bytes;
      logic [FPAGE_W-1:0]   free_page;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [START_W-1:0]   start_page;
      logic [COUNT_W-1:0]   page_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_SLOT,
      S_PAGE,
      S_MARK,
      S_FREE,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic size_chk;
      logic slot_step;
      logic page_step;
      logic free_step;
      logic mark_step;
      logic resp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic size_bad;
      logic slot_hit;
      logic slot_miss;
      logic page_hit;
      logic page_miss;
      logic free_hit;
      logic free_miss;
      logic mark_last;
      logic rsp_busy;
   } stat_type;

endpackage

// File: sv/pra_ram.sv
// ----------------------------------------------------------------------------
// pra_ram
// generic one-write one-read memory with registered read data
// ----------------------------------------------------------------------------
module pra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/pra_ctrl.sv
// ----------------------------------------------------------------------------
// pra_ctrl
// sequencer of the page run allocator: clear, scans, marking and response
// ----------------------------------------------------------------------------
module pra_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pra_pkg::op_type    req_op,
   input  pra_pkg::stat_type  stat,
   output pra_pkg::cmd_type   cmd
);
   import pra_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.mark_step = 1'b1;
            if (stat.mark_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_op == OP_FREE) ? S_FREE : S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.size_chk = 1'b1;
            state_in = stat.size_bad ? S_RESP : S_SLOT;
         end
         S_SLOT: begin
            cmd.slot_step = 1'b1;
            if (stat.slot_hit) begin
               state_in = S_PAGE;
            end else if (stat.slot_miss) begin
               state_in = S_RESP;
            end
         end
         S_PAGE: begin
            cmd.page_step = 1'b1;
            if (stat.page_hit) begin
               state_in = S_MARK;
            end else if (stat.page_miss) begin
               state_in = S_RESP;
            end
         end
         S_FREE: begin
            cmd.free_step = 1'b1;
            if (stat.free_hit) begin
               state_in = S_MARK;
            end else if (stat.free_miss) begin
               state_in = S_RESP;
            end
         end
         S_MARK: begin
            cmd.mark_step = 1'b1;
            if (stat.mark_last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!stat.rsp_busy) begin
               cmd.resp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: sv/pra_dp.sv
// ----------------------------------------------------------------------------
// pra_dp
// datapath of the page run allocator: page bitmap, slot table, scan units
// ----------------------------------------------------------------------------
module pra_dp #(
   parameter int HEAP_PAGES      = 1024,
   parameter int MAX_ALLOCATIONS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  pra_pkg::mode_type  mode,
   input  pra_pkg::req_type   req_data,
   input  pra_pkg::cmd_type   cmd,
   output pra_pkg::stat_type  stat,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output pra_pkg::rsp_type   rsp_data
);
   import pra_pkg::*;

   localparam int PAW  = (HEAP_PAGES > 1) ? $clog2(HEAP_PAGES) : 1;
   localparam int CNTW = $clog2(HEAP_PAGES + 1);
   localparam int SAW  = (MAX_ALLOCATIONS > 1) ? $clog2(MAX_ALLOCATIONS) : 1;
   localparam int SCW  = $clog2(MAX_ALLOCATIONS + 1);
   localparam logic [PAW-1:0] LAST_PAGE = PAW'(HEAP_PAGES - 1);
   localparam logic [CNTW-1:0] HEAP_CNT = CNTW'(HEAP_PAGES);
   localparam logic [SAW-1:0] LAST_SLOT = SAW'(MAX_ALLOCATIONS - 1);
   localparam logic [SCW-1:0] SLOT_CNT = SCW'(MAX_ALLOCATIONS);

   // request and size
   req_type           req_ff, req_in;
   logic [CNTW-1:0]   want_ff, want_in;
   logic [WANT_W-1:0] want_raw;
   // slot scan
   logic [SCW-1:0]    sidx_ff, sidx_in;
   logic [SAW-1:0]    slot_ff, slot_in;
   logic [SAW-1:0]    ev_s_ff, ev_s_in;
   logic              ev_s_last_ff, ev_s_last_in;
   logic              rd_s_v_ff, rd_s_v_in;
   logic [MAX_ALLOCATIONS-1:0] slot_valid_ff, slot_valid_in;
   // page scan
   logic [PAW-1:0]    iss_pos_ff, iss_pos_in;
   logic [CNTW-1:0]   iss_n_ff, iss_n_in;
   logic              rd_v_ff, rd_v_in;
   logic [PAW-1:0]    ev_pos_ff, ev_pos_in;
   logic              ev_last_ff, ev_last_in;
   logic [CNTW-1:0]   run_ff, run_in;
   logic [PAW-1:0]    start_ff, start_in;
   logic              have_ff, have_in;
   logic [CNTW-1:0]   best_len_ff, best_len_in;
   logic [PAW-1:0]    best_start_ff, best_start_in;
   logic [PAW-1:0]    roving_ff, roving_in;
   // page marking and clearing
   logic [PAW-1:0]    mark_pos_ff, mark_pos_in;
   logic [PAW-1:0]    mark_end_ff, mark_end_in;
   logic              mark_val_ff, mark_val_in;
   // result
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // memories
   logic [0:0]        page_rd;
   logic              slot_we;
   logic [2*PAW-1:0]  slot_wdata, slot_rd;

   // evaluation terms
   logic              used, slot_hit, free_hit, page_hit, exact, better, close_run;
   logic [CNTW-1:0]   base, run1, clen, nxt;
   logic [PAW-1:0]    nf_first, cstart, found_first, slot_lo, slot_hi;

   pra_ram #(.WIDTH(1), .DEPTH(HEAP_PAGES)) u_page_ram (
      .clock (clock),
      .we    (cmd.mark_step),
      .waddr (mark_pos_ff),
      .wdata (mark_val_ff),
      .raddr (iss_pos_ff),
      .rdata (page_rd)
   );

   pra_ram #(.WIDTH(2*PAW), .DEPTH(MAX_ALLOCATIONS)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_ff),
      .wdata (slot_wdata),
      .raddr (sidx_ff[SAW-1:0]),
      .rdata (slot_rd)
   );

   // size rounding
   assign want_raw = WANT_W'(({1'b0, req_ff.request_bytes} + (BYTES_W+1)'(PAGE_MASK))
                             >> PAGE_SHIFT);

   // run tracking over the page read in the previous cycle
   assign used      = page_rd[0];
   assign base      = (ev_pos_ff == '0) ? '0 : run_ff;
   assign run1      = base + CNTW'(1);
   assign nf_first  = (base == '0) ? ev_pos_ff : start_ff;
   assign close_run = used ? (run_ff != '0) : ev_last_ff;
   assign clen      = used ? run_ff : run1;
   assign cstart    = used ? start_ff : nf_first;
   assign exact     = close_run && (clen == want_ff);
   assign better    = close_run && (clen > want_ff) && (!have_ff || clen < best_len_ff);

   // page scan outcome
   always_comb begin
      page_hit    = 1'b0;
      found_first = nf_first;
      if (rd_v_ff) begin
         if (mode == MODE_BEST_FIT) begin
            if (exact) begin
               page_hit    = 1'b1;
               found_first = cstart;
            end else if (ev_last_ff && (have_ff || better)) begin
               page_hit    = 1'b1;
               found_first = better ? cstart : best_start_ff;
            end
         end else begin
            page_hit = !used && (run1 == want_ff);
         end
      end
   end

   assign nxt = CNTW'(found_first) + want_ff;

   // slot table lookups
   assign slot_hit = !slot_valid_ff[sidx_ff[SAW-1:0]];
   assign slot_lo  = slot_rd[2*PAW-1:PAW];
   assign slot_hi  = slot_rd[PAW-1:0];
   assign free_hit = rd_s_v_ff && slot_valid_ff[ev_s_ff]
                     && (32'(slot_lo) <= 32'(req_ff.free_page))
                     && (32'(req_ff.free_page) <= 32'(slot_hi));

   assign slot_we    = cmd.page_step && page_hit;
   assign slot_wdata = {found_first, PAW'(nxt - CNTW'(1))};

   // status to the controller
   always_comb begin
      stat           = '0;
      stat.size_bad  = (want_raw == '0) || (32'(want_raw) > 32'(HEAP_PAGES));
      stat.slot_hit  = slot_hit;
      stat.slot_miss = !slot_hit && (sidx_ff[SAW-1:0] == LAST_SLOT);
      stat.page_hit  = page_hit;
      stat.page_miss = rd_v_ff && ev_last_ff && !page_hit;
      stat.free_hit  = free_hit;
      stat.free_miss = rd_s_v_ff && ev_s_last_ff && !free_hit;
      stat.mark_last = (mark_pos_ff == mark_end_ff);
      stat.rsp_busy  = rsp_valid_ff && !rsp_ready;
   end

   // next values
   always_comb begin
      req_in        = req_ff;
      want_in       = want_ff;
      sidx_in       = sidx_ff;
      slot_in       = slot_ff;
      ev_s_in       = ev_s_ff;
      ev_s_last_in  = ev_s_last_ff;
      rd_s_v_in     = rd_s_v_ff;
      slot_valid_in = slot_valid_ff;
      iss_pos_in    = iss_pos_ff;
      iss_n_in      = iss_n_ff;
      rd_v_in       = rd_v_ff;
      ev_pos_in     = ev_pos_ff;
      ev_last_in    = ev_last_ff;
      run_in        = run_ff;
      start_in      = start_ff;
      have_in       = have_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      roving_in     = roving_ff;
      mark_pos_in   = mark_pos_ff;
      mark_end_in   = mark_end_ff;
      mark_val_in   = mark_val_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      // take a request
      if (cmd.load) begin
         req_in    = req_data;
         sidx_in   = '0;
         rd_s_v_in = 1'b0;
      end

      // size check
      if (cmd.size_chk) begin
         want_in = CNTW'(want_raw);
         res_in  = '{status: ST_BAD, start_page: '0, page_count: '0};
      end

      // lowest free slot, one per cycle
      if (cmd.slot_step) begin
         slot_in = sidx_ff[SAW-1:0];
         sidx_in = sidx_ff + SCW'(1);
         res_in  = '{status: ST_BAD, start_page: '0, page_count: '0};
         if (slot_hit) begin
            iss_pos_in = (mode == MODE_BEST_FIT) ? '0 : roving_ff;
            iss_n_in   = '0;
            rd_v_in    = 1'b0;
            run_in     = '0;
            have_in    = 1'b0;
         end
      end

      // page scan: issue one read and evaluate the previous one
      if (cmd.page_step) begin
         rd_v_in = 1'b0;
         if (iss_n_ff != HEAP_CNT) begin
            rd_v_in    = 1'b1;
            ev_pos_in  = iss_pos_ff;
            ev_last_in = (iss_n_ff == CNTW'(HEAP_PAGES - 1));
            iss_n_in   = iss_n_ff + CNTW'(1);
            iss_pos_in = (iss_pos_ff == LAST_PAGE) ? '0 : iss_pos_ff + PAW'(1);
         end
         if (rd_v_ff) begin
            run_in = used ? '0 : run1;
            if (!used) begin
               start_in = nf_first;
            end
            if (better) begin
               have_in       = 1'b1;
               best_len_in   = clen;
               best_start_in = cstart;
            end
         end
         res_in = '{status: ST_NO_RUN, start_page: '0, page_count: '0};
         if (page_hit) begin
            slot_valid_in[slot_ff] = 1'b1;
            mark_pos_in = found_first;
            mark_end_in = PAW'(nxt - CNTW'(1));
            mark_val_in = 1'b1;
            res_in = '{status: ST_OK, start_page: START_W'(found_first),
                       page_count: COUNT_W'(want_ff)};
            if (mode == MODE_NEXT_FIT) begin
               roving_in = (32'(nxt) >= 32'(HEAP_PAGES)) ? '0 : PAW'(nxt);
            end
         end
      end

      // free: search the slot table for the allocation holding the page
      if (cmd.free_step) begin
         rd_s_v_in = 1'b0;
         if (sidx_ff != SLOT_CNT) begin
            rd_s_v_in    = 1'b1;
            ev_s_in      = sidx_ff[SAW-1:0];
            ev_s_last_in = (sidx_ff[SAW-1:0] == LAST_SLOT);
            sidx_in      = sidx_ff + SCW'(1);
         end
         res_in = '{status: ST_NOT_FOUND, start_page: '0, page_count: '0};
         if (free_hit) begin
            slot_valid_in[ev_s_ff] = 1'b0;
            mark_pos_in = slot_lo;
            mark_end_in = slot_hi;
            mark_val_in = 1'b0;
            res_in = '{status: ST_OK, start_page: START_W'(slot_lo),
                       page_count: COUNT_W'(CNTW'(slot_hi) - CNTW'(slot_lo) + CNTW'(1))};
         end
      end

      // write one page of the bitmap
      if (cmd.mark_step) begin
         mark_pos_in = mark_pos_ff + PAW'(1);
      end

      // hand the result to the output register
      if (cmd.resp_load) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         roving_ff     <= '0;
         mark_pos_ff   <= '0;
         mark_end_ff   <= LAST_PAGE;
         mark_val_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rd_v_ff       <= 1'b0;
         rd_s_v_ff     <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         roving_ff     <= roving_in;
         mark_pos_ff   <= mark_pos_in;
         mark_end_ff   <= mark_end_in;
         mark_val_ff   <= mark_val_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_v_ff       <= rd_v_in;
         rd_s_v_ff     <= rd_s_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      want_ff       <= want_in;
      sidx_ff       <= sidx_in;
      slot_ff       <= slot_in;
      ev_s_ff       <= ev_s_in;
      ev_s_last_ff  <= ev_s_last_in;
      iss_pos_ff    <= iss_pos_in;
      iss_n_ff      <= iss_n_in;
      ev_pos_ff     <= ev_pos_in;
      ev_last_ff    <= ev_last_in;
      run_ff        <= run_in;
      start_ff      <= start_in;
      have_ff       <= have_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/page_run_allocator.sv
// ----------------------------------------------------------------------------
// page_run_allocator
// page-granular next-fit / best-fit allocator over a used-page bitmap
// ----------------------------------------------------------------------------
// After reset the block clears its page bitmap, one page a cycle, and
// takes no request until that is done. Requests are handled one at a
// time. An allocate first checks the size, then finds the lowest free
// slot, then scans the bitmap (one page read a cycle from the bitmap
// memory), marks the granted pages in the bitmap and responds. A free
// scans the slot table, one slot a cycle, then clears one page a cycle.
module page_run_allocator #(
   parameter int HEAP_PAGES      = 1024,
   parameter int MAX_ALLOCATIONS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pra_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pra_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import pra_pkg::*;

   mode_type mode_ff, mode_in;
   cmd_type  cmd;
   stat_type stat;

   // configuration register
   always_comb begin
      mode_in = mode_ff;
      if (psel && penable && pwrite && (paddr[2] == 1'(REG_PLACEMENT_MODE))) begin
         mode_in = mode_type'(pwdata[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NEXT_FIT;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'(REG_PLACEMENT_MODE)) ? {31'b0, mode_ff} : 32'b0;

   pra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_data.operation),
      .stat      (stat),
      .cmd       (cmd)
   );

   pra_dp #(
      .HEAP_PAGES      (HEAP_PAGES),
      .MAX_ALLOCATIONS (MAX_ALLOCATIONS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/pra_checker.sv
// ----------------------------------------------------------------------------
// pra_checker
// port-level checks of the page run allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "page_run_allocator_macros.svh"

module pra_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input pra_pkg::req_type  req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input pra_pkg::rsp_type  rsp_data
);
   import pra_pkg::*;

   // a stalled response holds
   `PRA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response dropped or changed while stalled")

   // one request at a time
   `PRA_ASSERT_NEXT(a_one_req, clock, reset, req_valid && req_ready, !req_ready, "request taken while another is in work")

   // error responses carry no pages
   `PRA_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && rsp_data.status != ST_OK, rsp_data.start_page == '0 && rsp_data.page_count == '0, "error response with nonzero fields")

   // a granted or released allocation has at least one page
   `PRA_ASSERT_IMP(a_ok_count, clock, reset, rsp_valid && rsp_data.status == ST_OK, rsp_data.page_count != '0, "ok response with zero pages")

endmodule

bind page_run_allocator pra_checker u_pra_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the page run allocator
// ----------------------------------------------------------------------------
// Requests go in over valid/ready. A scoreboard keeps its own copy of the page
// bitmap, slot table and roving pointer and predicts each response. The run
// starts with directed cases: zero size, oversize, no fitting run, a run
// blocked by the wrap, a full slot table and unknown pages. Random traffic
// follows in both placement modes, with stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import pra_pkg::*;

   localparam int NUM_PAGES  = 1024;
   localparam int NUM_SLOTS  = 256;
   localparam int PAGE_BYTES = 4096;
   localparam int STALL_LIMIT = 20000;

   // ---------------------------------------------------------------------------
   // reference allocator state and response checking
   // ---------------------------------------------------------------------------
   class allocator_scoreboard;
      bit                 page_busy [NUM_PAGES];
      bit                 slot_live [NUM_SLOTS];
      int                 slot_lo   [NUM_SLOTS];
      int                 slot_hi   [NUM_SLOTS];
      int                 rover;
      mode_type           mode;
      rsp_type            pending_rsp [$];
      int                 errors;
      int                 n_grant, n_release, n_no_run, n_bad, n_unknown;

      function void clear();
         foreach (page_busy[i]) page_busy[i] = 0;
         foreach (slot_live[i]) slot_live[i] = 0;
         rover  = 0;
         mode   = MODE_NEXT_FIT;
         errors = 0;
      endfunction

      // next-fit scan: one lap from the rover, runs broken at the wrap
      function bit scan_next_fit(int want, output int first);
         int pos, run, run_start;
         pos = rover;
         run = 0;
         run_start = 0;
         first = 0;
         for (int n = 0; n < NUM_PAGES; n++) begin
            if (pos == 0) run = 0;
            if (page_busy[pos]) begin
               run = 0;
            end else begin
               if (run == 0) run_start = pos;
               run++;
               if (run == want) begin
                  first = run_start;
                  return 1;
               end
            end
            pos = (pos + 1 >= NUM_PAGES) ? 0 : pos + 1;
         end
         return 0;
      endfunction

      // best fit: exact run first, else first of the smallest larger runs
      function bit scan_best_fit(int want, output int first);
         int p, s, len, best_len;
         bit have;
         have = 0;
         best_len = 0;
         first = 0;
         p = 0;
         while (p < NUM_PAGES) begin
            if (page_busy[p]) begin
               p++;
            end else begin
               s = p;
               while (p < NUM_PAGES && !page_busy[p]) p++;
               len = p - s;
               if (len == want) begin
                  first = s;
                  return 1;
               end
               if (len > want && (!have || len < best_len)) begin
                  have = 1;
                  best_len = len;
                  first = s;
               end
            end
         end
         return have;
      endfunction

      function rsp_type predict_alloc(logic [BYTES_W-1:0] bytes);
         rsp_type r;
         int want, slot, first;
         bit ok;
         r = '{status: ST_BAD, start_page: '0, page_count: '0};
         want = (int'(bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
         if (want == 0 || want > NUM_PAGES) return r;
         slot = NUM_SLOTS;
         for (int i = NUM_SLOTS - 1; i >= 0; i--)
            if (!slot_live[i]) slot = i;
         if (slot == NUM_SLOTS) return r;
         ok = (mode == MODE_BEST_FIT) ? scan_best_fit(want, first)
                                      : scan_next_fit(want, first);
         if (!ok) begin
            r.status = ST_NO_RUN;
            return r;
         end
         for (int i = 0; i < want; i++) page_busy[first + i] = 1;
         slot_lo[slot]   = first;
         slot_hi[slot]   = first + want - 1;
         slot_live[slot] = 1;
         if (mode == MODE_NEXT_FIT)
            rover = (first + want >= NUM_PAGES) ? 0 : first + want;
         r.status     = ST_OK;
         r.start_page = first[START_W-1:0];
         r.page_count = want[COUNT_W-1:0];
         return r;
      endfunction

      function rsp_type predict_free(logic [FPAGE_W-1:0] page);
         rsp_type r;
         r = '{status: ST_NOT_FOUND, start_page: '0, page_count: '0};
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (slot_live[s] && slot_lo[s] <= page && page <= slot_hi[s]) begin
               for (int p = slot_lo[s]; p <= slot_hi[s]; p++) page_busy[p] = 0;
               slot_live[s] = 0;
               r.status     = ST_OK;
               r.start_page = slot_lo[s][START_W-1:0];
               r.page_count = COUNT_W'(slot_hi[s] - slot_lo[s] + 1);
               return r;
            end
         end
         return r;
      endfunction

      function void note_request(req_type q);
         if (q.operation == OP_ALLOC) pending_rsp.push_back(predict_alloc(q.request_bytes));
         else                         pending_rsp.push_back(predict_free(q.free_page));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want_rsp;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response status=%0d start=%0d count=%0d",
                     $realtime, got.status, got.start_page, got.page_count);
            errors++;
            return;
         end
         want_rsp = pending_rsp.pop_front();
         if (got.status !== want_rsp.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime,
                     want_rsp.status, got.status);
            errors++;
         end
         if (got.start_page !== want_rsp.start_page) begin
            $display("%0t: start_page expected %0d actual %0d", $realtime,
                     want_rsp.start_page, got.start_page);
            errors++;
         end
         if (got.page_count !== want_rsp.page_count) begin
            $display("%0t: page_count expected %0d actual %0d", $realtime,
                     want_rsp.page_count, got.page_count);
            errors++;
         end
         case (want_rsp.status)
            ST_OK:        if (want_rsp.start_page == got.start_page) n_grant++;
            ST_NO_RUN:    n_no_run++;
            ST_NOT_FOUND: n_unknown++;
            default:      n_bad++;
         endcase
      endfunction

      // a page inside some live allocation, or a random page if none is live
      function logic [FPAGE_W-1:0] pick_live_page();
         int live [$];
         int s;
         foreach (slot_live[i]) if (slot_live[i]) live.push_back(i);
         if (live.size() == 0) return FPAGE_W'($urandom_range(0, NUM_PAGES - 1));
         s = live[$urandom_range(0, live.size() - 1)];
         return FPAGE_W'($urandom_range(slot_lo[s], slot_hi[s]));
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             psel;
   logic             penable;
   logic             pwrite;
   logic [2:0]       paddr;
   logic [31:0]      pwdata;
   logic [31:0]      prdata;
   logic             pready;

   allocator_scoreboard sb;
   bit                  quiet;
   int                  rsp_stall;
   int                  idle_cycles;
   int                  n_requests;

   page_run_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // response side: random stall bursts, none in the closing stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
         rsp_stall = 0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_stall = $urandom_range(0, 18);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one request, held until accepted, then an optional gap
   task automatic send(req_type q);
      int gap;
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note_request(q);
      n_requests++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_alloc(int bytes);
      req_type q;
      q.operation     = OP_ALLOC;
      q.request_bytes = bytes[BYTES_W-1:0];
      q.free_page     = FPAGE_W'($urandom);
      send(q);
   endtask

   task automatic send_free(int page);
      req_type q;
      q.operation     = OP_FREE;
      q.request_bytes = BYTES_W'($urandom);
      q.free_page     = page[FPAGE_W-1:0];
      send(q);
   endtask

   // wait until every response is in, with the request channel idle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_rsp.size() != 0) @(posedge clock);
   endtask

   // register write: setup cycle, then access cycle
   task automatic write_mode(mode_type m);
      drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 3'(4 * REG_PLACEMENT_MODE);
      pwdata  <= 32'(m);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.mode = m;
      @(posedge clock);
   endtask

   // random traffic: mostly small allocations and frees of live pages
   task automatic random_phase(int count);
      int r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 19);
         if (r < 9) begin
            send_alloc($urandom_range(1, 16 * PAGE_BYTES));
         end else if (r == 9) begin
            send_alloc($urandom_range(1, NUM_PAGES * PAGE_BYTES));
         end else if (r == 10) begin
            send_alloc($urandom & 32'h7F_FFFF);
         end else if (r == 11) begin
            send_alloc($urandom_range(0, PAGE_BYTES));
         end else if (r < 18) begin
            send_free(sb.pick_live_page());
         end else begin
            send_free($urandom_range(0, NUM_PAGES - 1));
         end
      end
   endtask

   initial begin
      sb = new();
      sb.clear();
      quiet       = 0;
      n_requests  = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: sizes, unknown pages, no fitting run, wrap
      write_mode(MODE_NEXT_FIT);
      send_alloc(0);
      send_alloc(1);
      send_alloc(PAGE_BYTES);
      send_alloc(PAGE_BYTES + 1);
      send_free(1);
      send_free(0);
      send_free(3);
      send_free(NUM_PAGES - 1);
      send_alloc(NUM_PAGES * PAGE_BYTES);
      send_alloc(1020 * PAGE_BYTES);
      send_free(600);
      send_alloc(NUM_PAGES * PAGE_BYTES);
      send_alloc(1);
      send_free(512);
      send_alloc(NUM_PAGES * PAGE_BYTES + 1);
      send_alloc(32'h7F_FFFF);
      send_alloc(1000 * PAGE_BYTES);
      send_free(5);
      send_alloc(30 * PAGE_BYTES);
      send_free(0);

      // full slot table; random frees below open it up again
      for (int i = 0; i < NUM_SLOTS; i++) send_alloc(PAGE_BYTES);
      send_alloc(PAGE_BYTES);

      // random phases across both placement modes
      write_mode(MODE_BEST_FIT);
      random_phase(50);
      write_mode(MODE_NEXT_FIT);
      random_phase(40);
      write_mode(MODE_BEST_FIT);
      quiet = 1;
      random_phase(30);
      send_free(NUM_PAGES - 1);
      drain();
      repeat (50) @(posedge clock);

      $display("%0d requests: %0d grants/releases, %0d no-run, %0d bad size or full,",
               n_requests, sb.n_grant, sb.n_no_run, sb.n_bad);
      $display("%0d unknown pages; both placement modes, stalls on both sides",
               sb.n_unknown);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
